// ----- rtl/lrbgd_pkg.sv -----
package lrbgd_pkg;

   localparam int FEATURES    = 4;
   localparam int MAX_SAMPLES = 1024;
   localparam int LANES       = FEATURES + 1;
   localparam int LANE_W      = $clog2(LANES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int X_W         = 16;
   localparam int W_W         = 32;
   localparam int P_W         = W_W + X_W;
   localparam int ACC_W       = 48;
   localparam int DIFF_W      = W_W + 1;
   localparam int GP_W        = DIFF_W + X_W;
   localparam int DIV_W       = ACC_W + 1;
   localparam int LR_W        = 16;

   localparam logic [LR_W-1:0]       LR_RESET = 16'd655;
   localparam logic signed [X_W-1:0] ONE_Q412 = 16'sd4096;

   localparam logic [1:0] REQ_PREDICT = 2'd0;
   localparam logic [1:0] REQ_TRAIN   = 2'd1;
   localparam logic [1:0] REQ_UPDATE  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_PRED,
      ST_GRAD,
      ST_ACC,
      ST_LOSS,
      ST_LOSS_WAIT,
      ST_STEP_MUL,
      ST_STEP_DIV,
      ST_STEP_WAIT,
      ST_STEP_WR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic mul;
      logic grad;
      logic acc;
      logic wr;
      logic clr;
   } lane_ctrl_type;

   typedef struct packed {
      logic [1:0]             req_type;
      logic signed [X_W-1:0]  feature_0;
      logic signed [X_W-1:0]  feature_1;
      logic signed [X_W-1:0]  feature_2;
      logic signed [X_W-1:0]  feature_3;
      logic signed [X_W-1:0]  target;
   } req_payload_type;

   typedef struct packed {
      logic signed [W_W-1:0] prediction;
      logic [31:0]           mean_loss;
      logic                  empty_batch;
      logic                  saturated;
   } rsp_payload_type;

endpackage

// ----- rtl/lrbgd_div.sv -----
module lrbgd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lrbgd_pkg::DIV_W-1:0] dividend,
   input  logic [lrbgd_pkg::CNT_W-1:0] divisor,
   output logic                        done,
   output logic [lrbgd_pkg::DIV_W-1:0] quotient
);
   import lrbgd_pkg::*;

   localparam int STEP_W = $clog2(DIV_W);

   logic [DIV_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              run_ff, done_ff;
   logic [CNT_W:0]    shifted, trial;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      trial   = shifted - {1'b0, dvs_ff};
      rem_in  = ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(DIV_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/lrbgd_lane.sv -----
module lrbgd_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  lrbgd_pkg::lane_ctrl_type           ctrl,
   input  logic signed [lrbgd_pkg::X_W-1:0]   x,
   input  logic signed [lrbgd_pkg::DIFF_W-1:0] diff,
   input  logic [lrbgd_pkg::DIV_W-1:0]        step,
   output logic signed [lrbgd_pkg::P_W-1:0]   prod,
   output logic signed [lrbgd_pkg::ACC_W-1:0] grad,
   output logic                               sat
);
   import lrbgd_pkg::*;

   localparam int GW = ACC_W + 2;
   localparam int WW = DIV_W + 2;
   localparam logic signed [GW-1:0] G_MAX = GW'({1'b0, {(ACC_W-1){1'b1}}});
   localparam logic signed [GW-1:0] G_MIN = ~G_MAX;
   localparam logic signed [WW-1:0] W_MAX = WW'({1'b0, {(W_W-1){1'b1}}});
   localparam logic signed [WW-1:0] W_MIN = ~W_MAX;

   logic signed [W_W-1:0]   weight_ff, weight_in;
   logic signed [ACC_W-1:0] grad_ff, grad_in;
   logic signed [P_W-1:0]   prod_ff;
   logic signed [GP_W-1:0]  gprod_ff;
   logic signed [GW-1:0]    gsum;
   logic signed [WW-1:0]    wsum, step_s;
   logic                    gsat, wsat;

   always_comb begin
      gsum   = GW'(grad_ff) + GW'(gprod_ff >>> 12);
      gsat   = (gsum > G_MAX) || (gsum < G_MIN);
      grad_in = (gsum > G_MAX) ? G_MAX[ACC_W-1:0] :
                (gsum < G_MIN) ? G_MIN[ACC_W-1:0] : gsum[ACC_W-1:0];
      step_s = $signed({2'b00, step});
      wsum   = grad_ff[ACC_W-1] ? WW'(weight_ff) + step_s : WW'(weight_ff) - step_s;
      wsat   = (wsum > W_MAX) || (wsum < W_MIN);
      weight_in = (wsum > W_MAX) ? W_MAX[W_W-1:0] :
                  (wsum < W_MIN) ? W_MIN[W_W-1:0] : wsum[W_W-1:0];
      sat = (ctrl.acc && gsat) || (ctrl.wr && wsat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
         grad_ff   <= '0;
      end else begin
         if (ctrl.wr) begin
            weight_ff <= weight_in;
         end
         if (ctrl.clr) begin
            grad_ff <= '0;
         end else if (ctrl.acc) begin
            grad_ff <= grad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         prod_ff <= weight_ff * x;
      end
      if (ctrl.grad) begin
         gprod_ff <= diff * x;
      end
   end

   assign prod = prod_ff;
   assign grad = grad_ff;

endmodule

// ----- rtl/linear_regression_batch_gd.sv -----
// Channel   Ports                                Direction  Beat
// request   start, busy, req_payload             in         start & !busy
// result    rsp_valid, rsp_payload               out        rsp_valid, one cycle
// config    psel, penable, pwrite, paddr, pwdata  in         psel & penable & pwrite
//
// A predict runs multiply, merge and round before its result beat; a train sample
// then adds gradient multiply and accumulate, unless the batch is already full.
// In an update the shared one-bit-per-cycle divider runs once for the loss and
// once per weight and the bias; an update on an empty batch skips the divider.
// busy stays high from accept through the result beat; reset is synchronous.
// Results cannot be stalled: each beat shows for exactly one cycle.
module linear_regression_batch_gd (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  lrbgd_pkg::req_payload_type  req_payload,
   output logic                        rsp_valid,
   output lrbgd_pkg::rsp_payload_type  rsp_payload,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import lrbgd_pkg::*;

   localparam int SUM_W  = P_W + LANE_W + 1;
   localparam int NUM_W  = LR_W + 1 + ACC_W;
   localparam int HALF_W = ACC_W / 2;
   localparam int PP_W   = LR_W + 1 + HALF_W;
   localparam int SQ_W   = ACC_W;
   localparam logic signed [SUM_W-1:0] PRED_MAX = SUM_W'({1'b0, {(W_W-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] PRED_MIN = ~PRED_MAX;

   state_type state_ff, state_in;
   req_payload_type req_ff;
   logic [LANE_W-1:0]       k_ff;
   logic signed [W_W-1:0]   pred_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic [63:0]             sq_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [PP_W-1:0]         num_lo_ff, num_hi_ff;
   logic [NUM_W-1:0]        num_sum;
   logic [31:0]             loss_ff;
   logic                    empty_ff, sat_ff;
   logic [SQ_W-1:0]         sqsum_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [LR_W-1:0]         lr_ff;

   lane_ctrl_type           ctrl;
   lane_ctrl_type           lane_ctrl [LANES];
   logic signed [X_W-1:0]   lane_x    [LANES];
   logic signed [P_W-1:0]   lane_prod [LANES];
   logic signed [ACC_W-1:0] lane_grad [LANES];
   logic [LANES-1:0]        lane_sat;

   logic signed [SUM_W-1:0] pred_wide;
   logic                    pred_clip;
   logic signed [W_W-1:0]   pred_val;
   logic signed [DIFF_W-1:0] diff_val;
   logic [31:0]             mag;
   logic [SQ_W:0]           sq_add;
   logic signed [ACC_W-1:0] gsel;
   logic [ACC_W-1:0]        gmag;
   logic                    full, is_train;
   logic                    div_start, div_done;
   logic [DIV_W-1:0]        div_dividend, div_q;
   logic                    accept, cfg_wr;

   assign accept = start && !busy;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? 32'(lr_ff) : 32'd0;

   assign lane_x[0] = req_ff.feature_0;
   assign lane_x[1] = req_ff.feature_1;
   assign lane_x[2] = req_ff.feature_2;
   assign lane_x[3] = req_ff.feature_3;
   assign lane_x[FEATURES] = ONE_Q412;

   genvar gi;
   generate
      for (gi = 0; gi < LANES; gi++) begin : g_lane
         always_comb begin
            lane_ctrl[gi]    = ctrl;
            lane_ctrl[gi].wr = ctrl.wr && (k_ff == LANE_W'(gi));
         end
         lrbgd_lane u_lane (
            .clock (clock),
            .reset (reset),
            .ctrl  (lane_ctrl[gi]),
            .x     (lane_x[gi]),
            .diff  (diff_ff),
            .step  (div_q),
            .prod  (lane_prod[gi]),
            .grad  (lane_grad[gi]),
            .sat   (lane_sat[gi])
         );
      end
   endgenerate

   lrbgd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      sum_in = SUM_W'(2048);
      for (int i = 0; i < LANES; i++) begin
         sum_in = sum_in + SUM_W'(lane_prod[i]);
      end
      pred_wide = sum_ff >>> 12;
      pred_clip = (pred_wide > PRED_MAX) || (pred_wide < PRED_MIN);
      pred_val  = (pred_wide > PRED_MAX) ? PRED_MAX[W_W-1:0] :
                  (pred_wide < PRED_MIN) ? PRED_MIN[W_W-1:0] : pred_wide[W_W-1:0];
      diff_val  = DIFF_W'(pred_val) - (DIFF_W'(req_ff.target) <<< 12);
      mag       = diff_ff[DIFF_W-1] ? 32'(-diff_ff) : 32'(diff_ff);
      sq_add    = {1'b0, sqsum_ff} + (SQ_W+1)'(sq_ff[63:24]);
      gsel      = lane_grad[k_ff];
      gmag      = gsel[ACC_W-1] ? ACC_W'(-gsel) : ACC_W'(gsel);
      num_sum   = {num_hi_ff, {HALF_W{1'b0}}} + NUM_W'(num_lo_ff) +
                  NUM_W'({cnt_ff, 15'b0});
      full      = cnt_ff >= CNT_W'(MAX_SAMPLES);
      is_train  = req_ff.req_type == REQ_TRAIN;
      div_dividend = (state_ff == ST_LOSS) ?
                     DIV_W'(sqsum_ff) + DIV_W'(cnt_ff >> 1) : num_sum[16 +: DIV_W];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.req_type != REQ_UPDATE) begin
                  state_in = ST_MUL;
               end else if (cnt_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_LOSS;
               end
            end
         end
         ST_MUL:       state_in = ST_SUM;
         ST_SUM:       state_in = ST_PRED;
         ST_PRED:      state_in = (is_train && !full) ? ST_GRAD : ST_OUT;
         ST_GRAD:      state_in = ST_ACC;
         ST_ACC:       state_in = ST_OUT;
         ST_LOSS:      state_in = ST_LOSS_WAIT;
         ST_LOSS_WAIT: state_in = div_done ? ST_STEP_MUL : ST_LOSS_WAIT;
         ST_STEP_MUL:  state_in = ST_STEP_DIV;
         ST_STEP_DIV:  state_in = ST_STEP_WAIT;
         ST_STEP_WAIT: state_in = div_done ? ST_STEP_WR : ST_STEP_WAIT;
         ST_STEP_WR:   state_in = (k_ff == LANE_W'(LANES - 1)) ? ST_OUT : ST_STEP_MUL;
         ST_OUT:       state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      div_start = 1'b0;
      busy      = state_ff != ST_IDLE;
      rsp_valid = state_ff == ST_OUT;
      case (state_ff)
         ST_MUL:      ctrl.mul  = 1'b1;
         ST_GRAD:     ctrl.grad = 1'b1;
         ST_ACC:      ctrl.acc  = 1'b1;
         ST_LOSS:     div_start = 1'b1;
         ST_STEP_DIV: div_start = 1'b1;
         ST_STEP_WR: begin
            ctrl.wr  = 1'b1;
            ctrl.clr = k_ff == LANE_W'(LANES - 1);
         end
         default: ctrl = '0;
      endcase
   end

   assign rsp_payload.prediction  = pred_ff;
   assign rsp_payload.mean_loss   = loss_ff;
   assign rsp_payload.empty_batch = empty_ff;
   assign rsp_payload.saturated   = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lr_ff    <= LR_RESET;
         sqsum_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr && paddr[2] == 1'b0) begin
            lr_ff <= pwdata[LR_W-1:0];
         end
         if (state_ff == ST_ACC) begin
            sqsum_ff <= sq_add[SQ_W] ? {SQ_W{1'b1}} : sq_add[SQ_W-1:0];
            cnt_ff   <= cnt_ff + CNT_W'(1);
         end
         if (state_ff == ST_STEP_WR && k_ff == LANE_W'(LANES - 1)) begin
            sqsum_ff <= '0;
            cnt_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_ff   <= req_payload;
               pred_ff  <= '0;
               loss_ff  <= '0;
               sat_ff   <= 1'b0;
               empty_ff <= (req_payload.req_type == REQ_UPDATE) && (cnt_ff == '0);
               k_ff     <= '0;
            end
         end
         ST_SUM:  sum_ff <= sum_in;
         ST_PRED: begin
            pred_ff <= pred_val;
            diff_ff <= diff_val;
            sat_ff  <= sat_ff | pred_clip | (is_train && full);
         end
         ST_GRAD: sq_ff <= 64'(mag) * 64'(mag);
         ST_ACC:  sat_ff <= sat_ff | (|lane_sat) | sq_add[SQ_W];
         ST_LOSS_WAIT: begin
            if (div_done) begin
               loss_ff <= (|div_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
               sat_ff  <= sat_ff | (|div_q[DIV_W-1:32]);
            end
         end
         ST_STEP_MUL: begin
            num_lo_ff <= PP_W'({lr_ff, 1'b0}) * PP_W'(gmag[HALF_W-1:0]);
            num_hi_ff <= PP_W'({lr_ff, 1'b0}) * PP_W'(gmag[ACC_W-1:HALF_W]);
         end
         ST_STEP_WR: begin
            sat_ff <= sat_ff | (|lane_sat);
            k_ff   <= k_ff + LANE_W'(1);
         end
         default: sat_ff <= sat_ff;
      endcase
   end

endmodule

// ----- bench/tb_linear_regression_batch_gd.sv -----
module tb_linear_regression_batch_gd;
   timeunit 1ns;
   timeprecision 1ps;
   import lrbgd_pkg::*;

   localparam logic [1:0] REQ_SPARE   = 2'd3;
   localparam logic [2:0] ADDR_LR     = 3'd0;
   localparam longint ACC_HI = 64'sd140737488355327;
   localparam longint ACC_LO = -64'sd140737488355328;
   localparam longint unsigned SQ_HI = 64'd281474976710655;
   localparam longint I32_HI = 64'sd2147483647;
   localparam longint I32_LO = -64'sd2147483648;

   typedef struct {
      req_payload_type beat;
      bit              known;
      rsp_payload_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   rsp_payload_type rsp_payload;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   int w_q [FEATURES];
   int bias_q;
   longint grad_sum [FEATURES];
   longint bias_grad_sum;
   longint unsigned sq_err_sum;
   int unsigned batch_count;
   longint unsigned step_rate;

   rsp_payload_type expected_q [$];
   row_type rows [$];
   int errors = 0;
   int beats_sent = 0;
   int updates_sent = 0;
   bit steady = 1'b0;

   linear_regression_batch_gd DUT (
      .clock, .reset, .start, .busy, .req_payload, .rsp_valid, .rsp_payload,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic longint clip(longint v, longint lo, longint hi, inout bit flag);
      if (v > hi) begin
         flag = 1'b1;
         return hi;
      end
      if (v < lo) begin
         flag = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic int step_weight(int w, longint g, inout bit flag);
      longint unsigned mag, den, num, st;
      mag = (g < 0) ? 64'd0 - longint'(g) : g;
      den = longint'(batch_count) << 16;
      num = 64'd2 * step_rate * mag;
      st = (num + den / 2) / den;
      return int'(clip((g < 0) ? longint'(w) + longint'(st) : longint'(w) - longint'(st),
                       I32_LO, I32_HI, flag));
   endfunction

   function automatic rsp_payload_type model_item(req_payload_type b);
      longint x [FEATURES];
      longint acc, diff;
      longint unsigned mag, sq, m;
      bit sat;
      rsp_payload_type r;
      sat = 1'b0;
      r = '0;
      x[0] = b.feature_0;
      x[1] = b.feature_1;
      x[2] = b.feature_2;
      x[3] = b.feature_3;
      if (b.req_type != REQ_UPDATE) begin
         acc = longint'(bias_q) * 4096;
         for (int j = 0; j < FEATURES; j++) acc += longint'(w_q[j]) * x[j];
         r.prediction = 32'(clip((acc + 2048) >>> 12, I32_LO, I32_HI, sat));
         if (b.req_type == REQ_TRAIN) begin
            if (batch_count >= MAX_SAMPLES) begin
               sat = 1'b1;
            end else begin
               diff = longint'(r.prediction) - longint'(b.target) * 4096;
               mag = (diff < 0) ? 64'd0 - diff : diff;
               sq = (mag * mag) >> 24;
               if (sq > SQ_HI - sq_err_sum) begin
                  sq_err_sum = SQ_HI;
                  sat = 1'b1;
               end else begin
                  sq_err_sum += sq;
               end
               for (int j = 0; j < FEATURES; j++)
                  grad_sum[j] = clip(grad_sum[j] + ((diff * x[j]) >>> 12), ACC_LO, ACC_HI, sat);
               bias_grad_sum = clip(bias_grad_sum + diff, ACC_LO, ACC_HI, sat);
               batch_count++;
            end
         end
      end else if (batch_count == 0) begin
         r.empty_batch = 1'b1;
      end else begin
         m = (sq_err_sum + batch_count / 2) / batch_count;
         if (m > 64'hFFFF_FFFF) begin
            m = 64'hFFFF_FFFF;
            sat = 1'b1;
         end
         r.mean_loss = m[31:0];
         for (int j = 0; j < FEATURES; j++) w_q[j] = step_weight(w_q[j], grad_sum[j], sat);
         bias_q = step_weight(bias_q, bias_grad_sum, sat);
         for (int j = 0; j < FEATURES; j++) grad_sum[j] = 0;
         bias_grad_sum = 0;
         sq_err_sum = 0;
         batch_count = 0;
      end
      r.saturated = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_payload.prediction !== want.prediction) begin
               $error("prediction: expected %0d, got %0d", want.prediction,
                      rsp_payload.prediction);
               errors++;
            end
            if (rsp_payload.mean_loss !== want.mean_loss) begin
               $error("mean_loss: expected %0d, got %0d", want.mean_loss,
                      rsp_payload.mean_loss);
               errors++;
            end
            if (rsp_payload.empty_batch !== want.empty_batch) begin
               $error("empty_batch: expected %0b, got %0b", want.empty_batch,
                      rsp_payload.empty_batch);
               errors++;
            end
            if (rsp_payload.saturated !== want.saturated) begin
               $error("saturated: expected %0b, got %0b", want.saturated,
                      rsp_payload.saturated);
               errors++;
            end
         end
      end
   end

   task automatic send_beat(req_payload_type b, bit known = 1'b0,
                            rsp_payload_type want = '0);
      rsp_payload_type r;
      @(negedge clock);
      start <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (busy);
      r = model_item(b);
      expected_q.insert(expected_q.size(), known ? want : r);
      beats_sent++;
      if (b.req_type == REQ_UPDATE) updates_sent++;
   endtask

   task automatic idle_gap();
      int gap;
      if (steady) return;
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_rate(logic [15:0] v);
      drain();
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= ADDR_LR;
      pwdata <= {16'h0, v};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      step_rate = v;
   endtask

   function automatic void add_row(req_payload_type b, bit known, rsp_payload_type want);
      row_type r;
      r.beat = b;
      r.known = known;
      r.want = want;
      rows.insert(rows.size(), r);
   endfunction

   function automatic logic [15:0] rand_field();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3, 4: return 16'($urandom_range(0, 16'hFFFF));
         default: return 16'($signed($urandom_range(0, 16384)) - 8192);
      endcase
   endfunction

   function automatic req_payload_type rand_beat(logic [1:0] kind);
      req_payload_type b;
      b.req_type  = kind;
      b.feature_0 = rand_field();
      b.feature_1 = rand_field();
      b.feature_2 = rand_field();
      b.feature_3 = rand_field();
      b.target    = rand_field();
      return b;
   endfunction

   task automatic run_batches(int total);
      int left, n;
      left = total;
      while (left > 0) begin
         steady = ($urandom_range(0, 4) == 0);
         n = $urandom_range(0, 12);
         if ($urandom_range(0, 9) == 0) n = $urandom_range(40, 120);
         for (int i = 0; i < n && left > 0; i++, left--) begin
            case ($urandom_range(0, 9))
               0: send_beat(rand_beat(REQ_PREDICT));
               1: send_beat(rand_beat(REQ_SPARE));
               default: send_beat(rand_beat(REQ_TRAIN));
            endcase
            idle_gap();
         end
         send_beat(rand_beat(REQ_UPDATE));
         left--;
         idle_gap();
      end
      steady = 1'b0;
   endtask

   rsp_payload_type zero_rsp, empty_rsp;
   req_payload_type hi_b, lo_b;

   initial begin
      for (int j = 0; j < FEATURES; j++) begin
         w_q[j] = 0;
         grad_sum[j] = 0;
      end
      bias_q = 0;
      bias_grad_sum = 0;
      sq_err_sum = 0;
      batch_count = 0;
      step_rate = LR_RESET;
      zero_rsp = '0;
      empty_rsp = '0;
      empty_rsp.empty_batch = 1'b1;
      hi_b = '{REQ_PREDICT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      lo_b = '{REQ_PREDICT, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};

      add_row(hi_b, 1'b1, zero_rsp);
      add_row(lo_b, 1'b1, zero_rsp);
      add_row('{REQ_SPARE, 16'sh1234, -16'sh0F00, 16'sh7FFF, 16'sh8000, 16'sh0001},
              1'b1, zero_rsp);
      add_row('{REQ_UPDATE, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, 1'b1, empty_rsp);
      add_row('{REQ_TRAIN, 16'sh1000, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, 1'b1, zero_rsp);
      add_row('{REQ_TRAIN, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000},
              1'b1, zero_rsp);
      add_row('{REQ_TRAIN, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF},
              1'b1, zero_rsp);
      add_row('{REQ_UPDATE, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, 1'b0, zero_rsp);
      add_row(hi_b, 1'b0, zero_rsp);
      add_row(lo_b, 1'b0, zero_rsp);
      add_row('{REQ_TRAIN, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, 1'b0, zero_rsp);
      add_row('{REQ_TRAIN, 16'sh1000, -16'sh1000, 16'sh0800, 16'sh0, 16'sh2000},
              1'b0, zero_rsp);
      add_row('{REQ_UPDATE, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, 1'b0, zero_rsp);
      add_row('{REQ_SPARE, 16'sh7FFF, 16'sh8000, 16'sh1000, 16'sh0, 16'sh0},
              1'b0, zero_rsp);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_beat(rows[i].beat, rows[i].known, rows[i].want);
         idle_gap();
      end

      write_rate(16'hFFFF);
      run_batches(150);
      drain();
      run_batches(50);
      write_rate(LR_RESET);
      run_batches(200);
      write_rate(16'($urandom_range(1, 16'hFFFE)));
      run_batches(150);
      write_rate(16'd1);
      run_batches(136);

      drain();
      $display("Sent %0d request beats (%0d updates) over several step-rate settings,",
               beats_sent, updates_sent);
      $display("including empty batches, spare codes and rate extremes.");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
